// ===== design/rlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlp_pkg
// Shared types and codes of the ring log pointer recovery unit.
// ----------------------------------------------------------------------------
package rlp_pkg;

  localparam int AddrW = 13;
  localparam int PtrW  = 14;
  localparam int MinW  = 24;
  localparam int ByteW = 8;

  // request kind codes
  localparam logic KIND_SLOT   = 1'b0;
  localparam logic KIND_APPEND = 1'b1;

  // configuration register indexes
  localparam logic REG_RECORD_LENGTH = 1'b0;
  localparam logic REG_VALID_MARKER  = 1'b1;

  localparam logic [ByteW-1:0] RecordLengthRst = 8'd8;
  localparam logic [ByteW-1:0] ValidMarkerRst  = 8'd165;

  typedef struct packed {
    logic             result_kind;
    logic [AddrW-1:0] write_address;
    logic [PtrW-1:0]  next_pointer;
  } result_t;

endpackage

// ===== design/rlp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlp_ctrl
// Recovery scan and append pointer state; computes the result of one request.
// ----------------------------------------------------------------------------
module rlp_ctrl #(
  parameter int MEMORY_BYTES = 8192
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [rlp_pkg::ByteW-1:0]  cfg_data_i,
  input  logic                       accept_i,
  input  logic                       kind_i,
  input  logic [rlp_pkg::ByteW-1:0]  slot_marker_i,
  input  logic [rlp_pkg::MinW-1:0]   slot_minutes_i,
  output logic                       res_valid_o,
  output rlp_pkg::result_t           res_o
);

  localparam int SW = $clog2(MEMORY_BYTES + 512);
  localparam int EW = SW + rlp_pkg::PtrW;
  localparam logic [SW-1:0] MemBytes = SW'(MEMORY_BYTES);

  logic [rlp_pkg::ByteW-1:0] rec_len_q, marker_q;
  logic                      done_q, done_d;
  logic                      seen_q, seen_d;
  logic [SW-1:0]             scan_q, scan_d;
  logic [SW-1:0]             best_base_q, best_base_d;
  logic [rlp_pkg::MinW-1:0]  best_min_q, best_min_d;
  logic [SW-1:0]             wp_q, wp_d;

  logic [SW-1:0] len, wp_fit, wp_next, scan_next, bb_new, fin_old, fin_new, fin_addr;
  logic          scan_fits, scan_more, hit, better, fin;

  function automatic logic [SW-1:0] wrap(input logic [SW-1:0] v);
    return (v >= MemBytes) ? '0 : v;
  endfunction

  function automatic logic [rlp_pkg::AddrW-1:0] to_addr(input logic [SW-1:0] v);
    logic [EW-1:0] e;
    e = EW'(v);
    return e[rlp_pkg::AddrW-1:0];
  endfunction

  function automatic logic [rlp_pkg::PtrW-1:0] to_ptr(input logic [SW-1:0] v);
    logic [EW-1:0] e;
    e = EW'(v);
    return e[rlp_pkg::PtrW-1:0];
  endfunction

  assign len       = SW'((rec_len_q == '0) ? 8'd1 : rec_len_q);
  assign wp_fit    = (wp_q + len > MemBytes) ? '0 : wp_q;
  assign wp_next   = wp_fit + len;
  assign scan_fits = (scan_q + len) <= MemBytes;
  assign scan_next = scan_q + len;
  assign scan_more = (scan_q + (len << 1)) <= MemBytes;
  assign hit       = slot_marker_i == marker_q;
  assign better    = !seen_q || (slot_minutes_i > best_min_q);
  assign bb_new    = better ? scan_q : best_base_q;
  assign fin_old   = seen_q ? wrap(best_base_q + len) : '0;
  assign fin_new   = wrap(bb_new + len);

  always_comb begin
    done_d      = done_q;
    seen_d      = seen_q;
    scan_d      = scan_q;
    best_base_d = best_base_q;
    best_min_d  = best_min_q;
    wp_d        = wp_q;
    fin         = 1'b0;
    fin_addr    = '0;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      if (kind_i == rlp_pkg::KIND_APPEND) begin
        wp_d                = wp_next;
        res_valid_o         = 1'b1;
        res_o.result_kind   = rlp_pkg::KIND_APPEND;
        res_o.write_address = to_addr(wp_fit);
        res_o.next_pointer  = to_ptr(wp_next);
      end else if (!done_q) begin
        if (!scan_fits) begin
          fin      = 1'b1;
          fin_addr = fin_old;
        end else if (!hit) begin
          fin      = 1'b1;
          fin_addr = scan_q;
        end else begin
          seen_d      = 1'b1;
          best_base_d = bb_new;
          if (better) begin
            best_min_d = slot_minutes_i;
          end
          scan_d = scan_next;
          if (!scan_more) begin
            fin      = 1'b1;
            fin_addr = fin_new;
          end
        end
        if (fin) begin
          done_d              = 1'b1;
          wp_d                = fin_addr;
          res_valid_o         = 1'b1;
          res_o.result_kind   = rlp_pkg::KIND_SLOT;
          res_o.write_address = to_addr(fin_addr);
          res_o.next_pointer  = to_ptr(fin_addr);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_len_q   <= rlp_pkg::RecordLengthRst;
      marker_q    <= rlp_pkg::ValidMarkerRst;
      done_q      <= 1'b0;
      seen_q      <= 1'b0;
      scan_q      <= '0;
      best_base_q <= '0;
      best_min_q  <= '0;
      wp_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          rlp_pkg::REG_RECORD_LENGTH: rec_len_q <= cfg_data_i;
          rlp_pkg::REG_VALID_MARKER:  marker_q  <= cfg_data_i;
        endcase
      end
      done_q      <= done_d;
      seen_q      <= seen_d;
      scan_q      <= scan_d;
      best_base_q <= best_base_d;
      best_min_q  <= best_min_d;
      wp_q        <= wp_d;
    end
  end

endmodule

// ===== design/rlp_outbuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlp_outbuf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module rlp_outbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  rlp_pkg::result_t res_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rlp_pkg::result_t out_o
);

  logic             out_valid_q, skid_valid_q;
  rlp_pkg::result_t out_q, skid_q;
  logic             out_fire;

  assign out_fire    = out_valid_q && out_ready_i;
  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_fire) begin
      out_valid_q <= res_valid_i;
    end else if (res_valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_fire) begin
      out_q <= res_i;
    end else if (res_valid_i) begin
      skid_q <= res_i;
    end
  end

endmodule

// ===== design/ring_log_pointer_recovery_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_log_pointer_recovery_unit
// Write pointer of a fixed-slot circular log: recovery scan and appends.
// ----------------------------------------------------------------------------
// channel   handshake                 payload
// in        in_valid_i / in_ready_o   kind_i, slot_marker_i, slot_minutes_i
// out       out_valid_o / out_ready_i result_kind_o, write_address_o,
//                                     next_pointer_o
// cfg       cfg_we_i (no wait)        cfg_index_i, cfg_data_i
//
// One request per cycle while in_ready_o is high; each result is registered before it shows.
// State update and result come from one pass of compare/add logic.
// A two-entry output buffer keeps requests flowing while a result waits;
// in_ready_o drops only while both entries are full.
// Reset takes effect at once; no clearing pass.
// ----------------------------------------------------------------------------
module ring_log_pointer_recovery_unit #(
  parameter int MEMORY_BYTES = 8192
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [rlp_pkg::ByteW-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic [rlp_pkg::ByteW-1:0]      slot_marker_i,
  input  logic [rlp_pkg::MinW-1:0]       slot_minutes_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           result_kind_o,
  output logic [rlp_pkg::AddrW-1:0]      write_address_o,
  output logic [rlp_pkg::PtrW-1:0]       next_pointer_o
);

  logic             accept, res_valid;
  rlp_pkg::result_t res, out_res;

  assign accept = in_valid_i && in_ready_o;

  rlp_ctrl #(
    .MEMORY_BYTES(MEMORY_BYTES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .accept_i       (accept),
    .kind_i         (kind_i),
    .slot_marker_i  (slot_marker_i),
    .slot_minutes_i (slot_minutes_i),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  rlp_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_res)
  );

  assign result_kind_o   = out_res.result_kind;
  assign write_address_o = out_res.write_address;
  assign next_pointer_o  = out_res.next_pointer;

endmodule

// ===== design/rlp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlp_checker
// Port-level checks of the ring log pointer recovery unit.
// ----------------------------------------------------------------------------
module rlp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      result_kind_o,
  input logic [rlp_pkg::AddrW-1:0] write_address_o,
  input logic [rlp_pkg::PtrW-1:0]  next_pointer_o
);

  logic rec_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_seen_q <= 1'b0;
    end else if (out_valid_o && out_ready_i && result_kind_o == rlp_pkg::KIND_SLOT) begin
      rec_seen_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o)
      && $stable(write_address_o) && $stable(next_pointer_o))
    else $error("result changed while stalled");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("not ready with empty output");

  a_rec_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == rlp_pkg::KIND_SLOT
      |-> {1'b0, write_address_o} == next_pointer_o)
    else $error("recovery result pointer mismatch");

  a_rec_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == rlp_pkg::KIND_SLOT |-> !rec_seen_q)
    else $error("second recovery result");

endmodule

bind ring_log_pointer_recovery_unit rlp_checker u_rlp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .result_kind_o   (result_kind_o),
  .write_address_o (write_address_o),
  .next_pointer_o  (next_pointer_o)
);
